### sv/b64d_pkg.sv
// Shared types, constants and the character map for the streaming Base64 decoder.
// No dependencies; imported by base64_stream_decoder_top.
`default_nettype none

package b64d_pkg;

    // Padding character
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Message status, one-hot
    typedef enum logic [2:0] {
        ST_RUNNING = 3'b001,
        ST_PADDED  = 3'b010,
        ST_FAILED  = 3'b100
    } msg_status_t;

    // Result of mapping one character
    typedef struct packed {
        logic       ok;
        logic [5:0] code;
    } char_map_t;

    // Map a character to its 6-bit code; bytes outside the alphabet are not ok
    function automatic char_map_t b64d_map(input logic [7:0] c);
        char_map_t r;
        r.ok   = 1'b1;
        r.code = 6'd0;
        if (c inside {[8'h41 : 8'h5A]}) begin
            r.code = 6'(c - 8'h41);
        end else if (c inside {[8'h61 : 8'h7A]}) begin
            r.code = 6'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30 : 8'h39]}) begin
            r.code = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            r.code = 6'd62;
        end else if (c == 8'h2F) begin
            r.code = 6'd63;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/base64_stream_decoder_top.sv
// Streaming Base64 decoder: one character word in, one result word out.
// Depends on b64d_pkg (status type, padding constant, character map).
//
// Takes one character per clock while the output side does not stall and
// returns one result word per character. Each character is first captured
// in an input register; the decode (character map, byte assembly from the
// previous code, group position and status update) sits between that
// register and the output register, so the sustained rate is one character
// per cycle while the output side keeps up. s_axis_tready follows
// m_axis_tready combinationally when both stages are full. A result with
// tuser bit 0 set carries a decoded byte; tlast marks the result of the last
// character of a message, with tuser bit 1 giving its status (1 = decoded
// correctly). Characters after padding or after an error are consumed and
// give empty results until the last character of the message.
`default_nettype none

module base64_stream_decoder_top (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Input channel
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  wire logic       s_axis_tlast,   // last_char
    // Result channel
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,   // msg_done
    output logic [1:0]      m_axis_tuser    // [0] out_valid, [1] msg_ok
);
    import b64d_pkg::*;

    // Input stage
    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        last_reg;

    // Decoder state
    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  prev_reg, prev_next;
    msg_status_t status_reg, status_next;

    // Output stage
    logic        out_valid_reg;
    logic [7:0]  byte_reg, byte_next;
    logic        bvalid_reg, bvalid_next;
    logic        done_reg;
    logic        ok_reg, ok_next;

    logic        out_free;
    logic        fire;
    logic        in_accept;
    char_map_t   cmap;
    logic        running;

    // Handshake: the output stage frees when empty or taken
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Capture the incoming word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (in_accept) begin
            char_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

    // Decode one character against the stored state
    assign cmap = b64d_map(char_reg);

    always_comb begin
        byte_next   = 8'd0;
        bvalid_next = 1'b0;
        ok_next     = 1'b0;
        phase_next  = phase_reg;
        prev_next   = prev_reg;
        status_next = status_reg;
        if (status_reg == ST_RUNNING) begin
            if (phase_reg[1] && char_reg == PAD_CHAR) begin
                status_next = ST_PADDED;
            end else if (!cmap.ok) begin
                status_next = ST_FAILED;
            end else begin
                case (phase_reg)
                    2'd1: begin
                        byte_next   = {prev_reg, cmap.code[5:4]};
                        bvalid_next = 1'b1;
                    end
                    2'd2: begin
                        byte_next   = {prev_reg[3:0], cmap.code[5:2]};
                        bvalid_next = 1'b1;
                    end
                    2'd3: begin
                        byte_next   = {prev_reg[1:0], cmap.code};
                        bvalid_next = 1'b1;
                    end
                    default: begin
                        bvalid_next = 1'b0;
                    end
                endcase
                prev_next  = cmap.code;
                phase_next = phase_reg + 2'd1;
            end
        end
        // Report status on the last word and start over
        if (last_reg) begin
            case (status_next)
                ST_RUNNING: ok_next = (phase_next != 2'd1);
                ST_PADDED:  ok_next = 1'b1;
                default:    ok_next = 1'b0;
            endcase
            phase_next  = 2'd0;
            prev_next   = 6'd0;
            status_next = ST_RUNNING;
        end
    end

    assign running = (status_reg == ST_RUNNING);

    // Advance decoder state when a word moves to the output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= 2'd0;
            prev_reg   <= 6'd0;
            status_reg <= ST_RUNNING;
        end else if (fire) begin
            phase_reg  <= phase_next;
            prev_reg   <= prev_next;
            status_reg <= status_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (fire) begin
            byte_reg   <= byte_next;
            bvalid_reg <= bvalid_next;
            done_reg   <= last_reg;
            ok_reg     <= ok_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = byte_reg;
    assign m_axis_tlast  = done_reg;
    assign m_axis_tuser  = {ok_reg, bvalid_reg};

    // Status is reported only on the last word of a message
    a_ok_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("msg_ok set on a non-final result");

    // A word without a decoded byte carries a zero byte
    a_empty_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
        else $error("nonzero byte on a result without data");

    // The last word of a message returns the decoder to its start state
    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && last_reg |=> phase_reg == 2'd0 && running)
        else $error("decoder state not cleared after last word");

    // Once ended or failed, the group position stays put until the last word
    a_hold_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !running && !last_reg |=> $stable(phase_reg) && !running)
        else $error("state moved after message end");

    // No byte comes out once the message has ended or failed
    a_no_byte_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !running |=> !bvalid_reg)
        else $error("byte emitted after message end");

endmodule

`default_nettype wire

### sim/tb_base64_stream_decoder_top.sv
// Self-checking testbench for base64_stream_decoder_top: directed and random Base64 messages,
// predicted word by word and checked against the result channel. Depends on b64d_pkg.
`timescale 1ns / 100ps

module tb_base64_stream_decoder_top;
    import b64d_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1450;

    // One expected result word
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       done;
        logic       ok;
    } decode_result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    wire        s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] char_in
    logic       s_axis_tlast = 1'b0;    // last_char
    wire        m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    wire  [7:0] m_axis_tdata;           // [7:0] out_byte
    wire        m_axis_tlast;           // msg_done
    wire  [1:0] m_axis_tuser;           // [0] out_valid, [1] msg_ok

    // Predictor state
    logic [1:0]  grp_pos = 2'd0;
    logic [5:0]  last_code = 6'd0;
    msg_status_t status = ST_RUNNING;
    decode_result_t pending_results[$];

    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    bit hold_req = 1'b0;
    int n_chars = 0;
    int n_checked = 0;
    int n_bytes = 0;
    int n_msgs_ok = 0;
    int n_msgs_bad = 0;
    int n_errors = 0;
    int cycles = 0;

    base64_stream_decoder_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 aclk = ~aclk;

    // Map a character to its 6-bit code; return 0 for bytes outside the alphabet
    function automatic logic char_code(input logic [7:0] c, output logic [5:0] code);
        code = 6'd0;
        if (c >= "A" && c <= "Z") begin
            code = 6'(c - "A");
        end else if (c >= "a" && c <= "z") begin
            code = 6'(c - "a" + 26);
        end else if (c >= "0" && c <= "9") begin
            code = 6'(c - "0" + 52);
        end else if (c == "+") begin
            code = 6'd62;
        end else if (c == "/") begin
            code = 6'd63;
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Inverse of the map, for building well-formed messages
    function automatic logic [7:0] code_char(input logic [5:0] code);
        if (code < 26) return 8'("A" + code);
        if (code < 52) return 8'("a" + code - 26);
        if (code < 62) return 8'("0" + code - 52);
        return (code == 6'd62) ? 8'("+") : 8'("/");
    endfunction

    // Advance the predictor by one accepted character and queue its result word
    task automatic decode_char(input logic [7:0] c, input logic last);
        decode_result_t r;
        logic [5:0] code;
        r = '0;
        if (status == ST_RUNNING) begin
            if (grp_pos >= 2'd2 && c == PAD_CHAR) begin
                status = ST_PADDED;
            end else if (!char_code(c, code)) begin
                status = ST_FAILED;
            end else begin
                case (grp_pos)
                    2'd1: r.data = {last_code, code[5:4]};
                    2'd2: r.data = {last_code[3:0], code[5:2]};
                    2'd3: r.data = {last_code[1:0], code};
                    default: r.data = 8'h00;
                endcase
                r.has_byte = (grp_pos != 2'd0);
                last_code = code;
                grp_pos = grp_pos + 2'd1;
            end
        end
        if (last) begin
            r.done = 1'b1;
            if (status == ST_RUNNING) r.ok = (grp_pos != 2'd1);
            else r.ok = (status == ST_PADDED);
            grp_pos = 2'd0;
            last_code = 6'd0;
            status = ST_RUNNING;
        end
        pending_results.push_back(r);
    endtask

    task automatic flag_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycles, what);
        n_errors++;
    endtask

    // Offer one character word and wait until it is taken
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        @(posedge aclk);
        decode_char(c, last);
        n_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // Build one message: mostly well-formed with random content, some broken
    task automatic send_random_msg();
        logic [7:0] msg[$];
        int ngroups;
        int tail;
        int pos;
        ngroups = ($urandom_range(7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
        for (int i = 0; i < 4 * ngroups; i++) msg.push_back(code_char(6'($urandom_range(63))));
        tail = $urandom_range(6);
        if (tail >= 1 && tail <= 3) begin
            // partial group: one char truncates, two or three are fine
            repeat (tail) msg.push_back(code_char(6'($urandom_range(63))));
        end else if (tail >= 4) begin
            repeat (tail == 5 ? 3 : 2) msg.push_back(code_char(6'($urandom_range(63))));
            msg.push_back(PAD_CHAR);
            if (tail == 4) msg.push_back(PAD_CHAR);
            // trailing junk after padding is dropped by the block
            if ($urandom_range(1)) repeat ($urandom_range(1, 3))
                msg.push_back(8'($urandom_range(255)));
        end
        if (msg.size() == 0) msg.push_back(code_char(6'($urandom_range(63))));
        // corrupt some messages with any byte or a misplaced pad
        if ($urandom_range(99) < 20) begin
            pos = $urandom_range(msg.size() - 1);
            msg[pos] = $urandom_range(1) ? 8'($urandom_range(255)) : PAD_CHAR;
        end
        foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);
    endtask

    task automatic run_random(input int n_items);
        int stop_at;
        stop_at = n_chars + n_items;
        while (n_chars < stop_at) send_random_msg();
    endtask

    // Alphabet extremes, padding in every position, invalid and truncated cases
    task automatic test_directed();
        send_text("TWFuAZaz09+/");
        send_text("TQ=");
        send_char(8'h80, 1'b1);
        send_text("TWE=");
        send_text("=");
        send_text("Q=");
        send_text("A");
        send_char(8'hFF, 1'b0);
        send_char("A", 1'b1);
    endtask

    // Stall the result side for a long stretch while characters keep coming
    task automatic test_backpressure();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        hold_req = 1'b1;
        repeat (3) send_text("QmFja3ByZXNzdXJl");
    endtask

    task automatic test_random_phases();
        src_gap_pct = 10;
        sink_stall_pct = 58;
        run_random(RANDOM_ITEMS / 3);
        src_gap_pct = 58;
        sink_stall_pct = 10;
        run_random(RANDOM_ITEMS / 3);
        src_gap_pct = 0;
        sink_stall_pct = 0;
        run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    endtask

    // Result-side ready: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(negedge aclk) begin
        decode_result_t exp_r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result word data=%02h", m_axis_tdata));
            end else begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (m_axis_tdata !== exp_r.data)
                    flag_mismatch($sformatf("out_byte %02h, want %02h", m_axis_tdata, exp_r.data));
                if (m_axis_tuser[0] !== exp_r.has_byte)
                    flag_mismatch($sformatf("out_valid %b, want %b", m_axis_tuser[0],
                                            exp_r.has_byte));
                if (m_axis_tlast !== exp_r.done)
                    flag_mismatch($sformatf("msg_done %b, want %b", m_axis_tlast, exp_r.done));
                if (m_axis_tuser[1] !== exp_r.ok)
                    flag_mismatch($sformatf("msg_ok %b, want %b", m_axis_tuser[1], exp_r.ok));
                if (exp_r.has_byte) n_bytes++;
                if (exp_r.done && exp_r.ok) n_msgs_ok++;
                if (exp_r.done && !exp_r.ok) n_msgs_bad++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     pending_results.size());
            $display("base64_stream_decoder_top regression: fail");
            $finish;
        end
    end

    initial begin
        m_axis_tready <= 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_phases();
        test_backpressure();
        // drain
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("covered %0d characters, %0d result words checked, %0d decoded bytes",
                 n_chars, n_checked, n_bytes);
        $display("messages ok %0d, failed %0d, mismatches %0d", n_msgs_ok, n_msgs_bad,
                 n_errors);
        if (n_errors == 0) begin
            $display("base64_stream_decoder_top regression: pass");
        end else begin
            $display("base64_stream_decoder_top regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
sv/b64d_pkg.sv
sv/base64_stream_decoder_top.sv
sim/tb_base64_stream_decoder_top.sv
